### hdl/glyph_quad_layout_macros.svh
// Assertion macros for the glyph quad layout block.
`ifndef GLYPH_QUAD_LAYOUT_MACROS_SVH
`define GLYPH_QUAD_LAYOUT_MACROS_SVH
`ifndef SYNTHESIS
`define GLQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glq check failed: same-cycle implication");
`define GLQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glq check failed: next-cycle implication");
`else
`define GLQ_ASSERT_IMP(label, ante, cons)
`define GLQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hdl/glq_pkg.sv
// Shared types, constants and arithmetic helpers for the glyph quad layout block.
`default_nettype none
package glq_pkg;

    localparam int SCALE_W    = 24;
    localparam int PAD_W      = 16;
    localparam int UNITS_W    = 16;
    localparam int RECT_W     = 23;
    localparam int COLOUR_W   = 24;
    localparam int ATLAS_W    = 16;
    localparam int TEX_W      = 17;
    localparam int POS_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // product, scaled value, two-term sum, quad extent, wide pen math
    localparam int PROD_W    = 41;
    localparam int SCL_W     = 28;
    localparam int SUM_W     = 29;
    localparam int QD_W      = 30;
    localparam int WIDE_W    = 32;
    localparam int RND_SHIFT = 12;

    localparam logic signed [PROD_W-1:0] RND_HALF = 41'sd2048;
    localparam logic signed [WIDE_W-1:0] SAT_HI   = 32'sd8388607;
    localparam logic signed [WIDE_W-1:0] SAT_LO   = -32'sd8388608;

    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_PIXELS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ASCENDER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DESCENDER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_GAP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COLOUR      = 3'd7;

    localparam logic [SCALE_W-1:0]  SCALE_RESET  = 24'h100000;
    localparam logic [RECT_W-1:0]   RECT_RESET   = 23'h7FFFFF;
    localparam logic [COLOUR_W-1:0] COLOUR_RESET = 24'hFFFFFF;

    localparam logic REQ_GLYPH   = 1'b0;
    localparam logic REQ_NEWLINE = 1'b1;

    // vertex order BL, TL, TR, TR, BR, BL (y grows downward); bit k is vertex k
    localparam int VCNT_W = 3;
    localparam logic [VCNT_W-1:0] LAST_VERT = 3'd5;
    localparam logic [5:0] CORNER_X = 6'b011100;
    localparam logic [5:0] CORNER_Y = 6'b110001;

    localparam int Q_AW     = 1;
    localparam int Q_DEPTH  = 1 << Q_AW;
    localparam int Q_CNT_W  = Q_AW + 1;

    typedef struct packed {
        logic [SCALE_W-1:0]      glyph_scale;
        logic [PAD_W-1:0]        pad_pixels;
        logic [RECT_W-1:0]       rect_width;
        logic [RECT_W-1:0]       rect_height;
        logic [COLOUR_W-1:0]     colour_rgb;
        logic signed [SCL_W-1:0] asc_s;
        logic signed [QD_W-1:0]  line_h;
    } cfg_t;

    typedef struct packed {
        logic                    is_nl;
        logic                    start;
        logic signed [SCL_W-1:0] adv;
        logic signed [SUM_W-1:0] lx;
        logic signed [SCL_W-1:0] y1;
        logic signed [QD_W-1:0]  qw;
        logic signed [QD_W-1:0]  qh;
        logic [ATLAS_W-1:0]      au;
        logic [ATLAS_W-1:0]      av;
        logic [ATLAS_W-1:0]      aw;
        logic [ATLAS_W-1:0]      ah;
    } item_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } q_stat_t;

    typedef struct packed {
        logic halted;
        logic busy;
        logic load;
    } back_stat_t;

    // font units times scale, plus the rounding half
    function automatic logic signed [PROD_W-1:0] mul_units(
        input logic signed [UNITS_W-1:0] v,
        input logic [SCALE_W-1:0]        s
    );
        logic signed [PROD_W-1:0] a;
        logic signed [PROD_W-1:0] b;
        a = PROD_W'(v);
        b = $signed(PROD_W'(s));
        return a * b + RND_HALF;
    endfunction

    // floor shift of a rounded product down to Q.8 pixels
    function automatic logic signed [SCL_W-1:0] round_prod(
        input logic signed [PROD_W-1:0] p
    );
        return $signed(p[RND_SHIFT+SCL_W-1:RND_SHIFT]);
    endfunction

    function automatic logic signed [POS_W-1:0] sat24(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] c;
        if (v > SAT_HI)
            c = SAT_HI;
        else if (v < SAT_LO)
            c = SAT_LO;
        else
            c = v;
        return $signed(c[POS_W-1:0]);
    endfunction

endpackage
`default_nettype wire

### hdl/glq_req_if.sv
// Request channel: one glyph or newline word per handshake.
`default_nettype none
interface glq_req_if;
    import glq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic                      start_of_text;
    logic signed [UNITS_W-1:0] advance;
    logic signed [UNITS_W-1:0] left_bearing;
    logic signed [UNITS_W-1:0] box_x0;
    logic signed [UNITS_W-1:0] box_y0;
    logic signed [UNITS_W-1:0] box_x1;
    logic signed [UNITS_W-1:0] box_y1;
    logic [ATLAS_W-1:0]        atlas_u;
    logic [ATLAS_W-1:0]        atlas_v;
    logic [ATLAS_W-1:0]        atlas_w;
    logic [ATLAS_W-1:0]        atlas_h;

    modport source (
        output valid, req_type, start_of_text, advance, left_bearing,
               box_x0, box_y0, box_x1, box_y1, atlas_u, atlas_v, atlas_w, atlas_h,
        input  ready
    );

    modport sink (
        input  valid, req_type, start_of_text, advance, left_bearing,
               box_x0, box_y0, box_x1, box_y1, atlas_u, atlas_v, atlas_w, atlas_h,
        output ready
    );
endinterface
`default_nettype wire

### hdl/glq_vtx_if.sv
// Vertex channel: one textured, colored vertex word per handshake.
`default_nettype none
interface glq_vtx_if;
    import glq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] vertex_x;
    logic signed [POS_W-1:0] vertex_y;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic [COLOUR_W-1:0]     vertex_colour;
    logic                    last_vertex;

    modport source (
        output valid, vertex_x, vertex_y, tex_u, tex_v, vertex_colour, last_vertex,
        input  ready
    );

    modport sink (
        input  valid, vertex_x, vertex_y, tex_u, tex_v, vertex_colour, last_vertex,
        output ready
    );
endinterface
`default_nettype wire

### hdl/glq_cfg.sv
// Configuration registers and derived font metrics (scaled ascender, line height).
`default_nettype none
module glq_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [glq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [glq_pkg::CFG_DATA_W-1:0] cfg_data,
    output glq_pkg::cfg_t                  cfg
);
    import glq_pkg::*;

    logic [SCALE_W-1:0]        glyph_scale_reg;
    logic [PAD_W-1:0]          pad_pixels_reg;
    logic signed [UNITS_W-1:0] ascender_reg;
    logic signed [UNITS_W-1:0] descender_reg;
    logic signed [UNITS_W-1:0] line_gap_reg;
    logic [RECT_W-1:0]         rect_width_reg;
    logic [RECT_W-1:0]         rect_height_reg;
    logic [COLOUR_W-1:0]       colour_reg;

    logic signed [PROD_W-1:0]  asc_p_reg;
    logic signed [PROD_W-1:0]  desc_p_reg;
    logic signed [PROD_W-1:0]  gap_p_reg;
    logic signed [SCL_W-1:0]   asc_s_reg;
    logic signed [QD_W-1:0]    line_h_reg;

    logic signed [QD_W-1:0]    line_h_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_scale_reg <= SCALE_RESET;
            pad_pixels_reg  <= '0;
            ascender_reg    <= '0;
            descender_reg   <= '0;
            line_gap_reg    <= '0;
            rect_width_reg  <= RECT_RESET;
            rect_height_reg <= RECT_RESET;
            colour_reg      <= COLOUR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GLYPH_SCALE: glyph_scale_reg <= cfg_data[SCALE_W-1:0];
                REG_PAD_PIXELS:  pad_pixels_reg  <= cfg_data[PAD_W-1:0];
                REG_ASCENDER:    ascender_reg    <= $signed(cfg_data[UNITS_W-1:0]);
                REG_DESCENDER:   descender_reg   <= $signed(cfg_data[UNITS_W-1:0]);
                REG_LINE_GAP:    line_gap_reg    <= $signed(cfg_data[UNITS_W-1:0]);
                REG_RECT_WIDTH:  rect_width_reg  <= cfg_data[RECT_W-1:0];
                REG_RECT_HEIGHT: rect_height_reg <= cfg_data[RECT_W-1:0];
                REG_COLOUR:      colour_reg      <= cfg_data[COLOUR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign line_h_next = QD_W'(round_prod(asc_p_reg)) - QD_W'(round_prod(desc_p_reg))
                       + QD_W'(round_prod(gap_p_reg));

    // two stage derivation: scaled products, then scaled ascender and line height
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asc_p_reg  <= RND_HALF;
            desc_p_reg <= RND_HALF;
            gap_p_reg  <= RND_HALF;
            asc_s_reg  <= '0;
            line_h_reg <= '0;
        end
        else
        begin
            asc_p_reg  <= mul_units(ascender_reg, glyph_scale_reg);
            desc_p_reg <= mul_units(descender_reg, glyph_scale_reg);
            gap_p_reg  <= mul_units(line_gap_reg, glyph_scale_reg);
            asc_s_reg  <= round_prod(asc_p_reg);
            line_h_reg <= line_h_next;
        end
    end

    always_comb
    begin
        cfg.glyph_scale = glyph_scale_reg;
        cfg.pad_pixels  = pad_pixels_reg;
        cfg.rect_width  = rect_width_reg;
        cfg.rect_height = rect_height_reg;
        cfg.colour_rgb  = colour_reg;
        cfg.asc_s       = asc_s_reg;
        cfg.line_h      = line_h_reg;
    end

endmodule
`default_nettype wire

### hdl/glq_front.sv
// Front end: accepts request words, scales the metrics and builds queue entries.
`default_nettype none
module glq_front (
    input  logic           clk,
    input  logic           rst_n,
    input  glq_pkg::cfg_t  cfg,
    glq_req_if.sink        req,
    input  logic           q_full,
    output logic           push,
    output glq_pkg::item_t push_item
);
    import glq_pkg::*;

    logic                     p_valid_reg;
    logic                     p_valid_next;
    logic                     p_is_nl_reg;
    logic                     p_start_reg;
    logic signed [PROD_W-1:0] p_adv_reg;
    logic signed [PROD_W-1:0] p_lsb_reg;
    logic signed [PROD_W-1:0] p_x0_reg;
    logic signed [PROD_W-1:0] p_y0_reg;
    logic signed [PROD_W-1:0] p_x1_reg;
    logic signed [PROD_W-1:0] p_y1_reg;
    logic [ATLAS_W-1:0]       p_au_reg;
    logic [ATLAS_W-1:0]       p_av_reg;
    logic [ATLAS_W-1:0]       p_aw_reg;
    logic [ATLAS_W-1:0]       p_ah_reg;

    logic                     accept;
    logic signed [SCL_W-1:0]  lsb_s;
    logic signed [SCL_W-1:0]  x0_s;
    logic signed [SCL_W-1:0]  y0_s;
    logic signed [SCL_W-1:0]  x1_s;
    logic signed [QD_W-1:0]   pad2;

    assign req.ready = !p_valid_reg || !q_full;
    assign accept    = req.valid && req.ready;
    assign push      = p_valid_reg && !q_full;

    always_comb
    begin
        p_valid_next = p_valid_reg;
        if (accept)
            p_valid_next = 1'b1;
        else if (push)
            p_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else
            p_valid_reg <= p_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_is_nl_reg <= (req.req_type == REQ_NEWLINE);
            p_start_reg <= req.start_of_text;
            p_adv_reg   <= mul_units(req.advance, cfg.glyph_scale);
            p_lsb_reg   <= mul_units(req.left_bearing, cfg.glyph_scale);
            p_x0_reg    <= mul_units(req.box_x0, cfg.glyph_scale);
            p_y0_reg    <= mul_units(req.box_y0, cfg.glyph_scale);
            p_x1_reg    <= mul_units(req.box_x1, cfg.glyph_scale);
            p_y1_reg    <= mul_units(req.box_y1, cfg.glyph_scale);
            p_au_reg    <= req.atlas_u;
            p_av_reg    <= req.atlas_v;
            p_aw_reg    <= req.atlas_w;
            p_ah_reg    <= req.atlas_h;
        end
    end

    assign lsb_s = round_prod(p_lsb_reg);
    assign x0_s  = round_prod(p_x0_reg);
    assign y0_s  = round_prod(p_y0_reg);
    assign x1_s  = round_prod(p_x1_reg);
    assign pad2  = $signed(QD_W'({cfg.pad_pixels, 1'b0}));

    always_comb
    begin
        push_item.is_nl = p_is_nl_reg;
        push_item.start = p_start_reg;
        push_item.adv   = round_prod(p_adv_reg);
        push_item.lx    = SUM_W'(lsb_s) + SUM_W'(x0_s);
        push_item.y1    = round_prod(p_y1_reg);
        push_item.qw    = QD_W'(x1_s) - QD_W'(x0_s) + pad2;
        push_item.qh    = QD_W'(push_item.y1) - QD_W'(y0_s) + pad2;
        push_item.au    = p_au_reg;
        push_item.av    = p_av_reg;
        push_item.aw    = p_aw_reg;
        push_item.ah    = p_ah_reg;
    end

endmodule
`default_nettype wire

### hdl/glq_queue.sv
// Short queue of classified items between the front and back ends.
`default_nettype none
module glq_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  glq_pkg::item_t    push_item,
    input  logic              pop,
    output glq_pkg::item_t    head_item,
    output glq_pkg::q_stat_t  stat
);
    import glq_pkg::*;

    item_t              entry_reg [Q_DEPTH];
    logic [Q_AW-1:0]    wr_ptr_reg;
    logic [Q_AW-1:0]    rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + Q_CNT_W'(1);
            2'b01:   count_next = count_reg - Q_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    assign head_item  = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

endmodule
`default_nettype wire

### hdl/glq_back.sv
// Back end: pen tracking, wrap and halt, and six-vertex quad emission.
`default_nettype none
module glq_back (
    input  logic                clk,
    input  logic                rst_n,
    input  glq_pkg::cfg_t       cfg,
    input  glq_pkg::item_t      head_item,
    input  logic                q_empty,
    output logic                pop,
    glq_vtx_if.source           vtx,
    output glq_pkg::back_stat_t stat
);
    import glq_pkg::*;

    localparam logic ST_DECODE = 1'b0;
    localparam logic ST_PLACE  = 1'b1;

    logic                     state_reg;
    logic                     state_next;
    logic signed [POS_W-1:0]  pen_x_reg;
    logic signed [POS_W-1:0]  pen_x_next;
    logic signed [POS_W-1:0]  pen_y_reg;
    logic signed [POS_W-1:0]  pen_y_next;
    logic                     halted_reg;
    logic                     halted_next;
    logic                     wrap_reg;
    logic signed [POS_W-1:0]  ny_reg;
    item_t                    g_reg;

    logic                     busy_reg;
    logic                     busy_next;
    logic [VCNT_W-1:0]        k_reg;
    logic [VCNT_W-1:0]        k_next;
    logic signed [WIDE_W-1:0] e_ox_reg;
    logic signed [WIDE_W-1:0] e_oy_reg;
    logic signed [QD_W-1:0]   e_qw_reg;
    logic signed [QD_W-1:0]   e_qh_reg;
    logic [ATLAS_W-1:0]       e_au_reg;
    logic [ATLAS_W-1:0]       e_av_reg;
    logic [ATLAS_W-1:0]       e_aw_reg;
    logic [ATLAS_W-1:0]       e_ah_reg;

    logic                     out_valid_reg;
    logic signed [POS_W-1:0]  out_x_reg;
    logic signed [POS_W-1:0]  out_y_reg;
    logic [TEX_W-1:0]         out_u_reg;
    logic [TEX_W-1:0]         out_v_reg;
    logic [COLOUR_W-1:0]      out_colour_reg;
    logic                     out_last_reg;

    // decode step
    logic signed [POS_W-1:0]  pen_x_e;
    logic signed [POS_W-1:0]  pen_y_e;
    logic                     halted_e;
    logic signed [POS_W-1:0]  nl_y;
    logic                     wrap;
    logic signed [WIDE_W-1:0] rect_w_wide;
    logic signed [WIDE_W-1:0] rect_h_wide;

    // place step
    logic signed [POS_W-1:0]  pen_x_w;
    logic signed [POS_W-1:0]  pen_y_w;
    logic                     halt;
    logic signed [WIDE_W-1:0] ox;
    logic signed [WIDE_W-1:0] oy;
    logic signed [POS_W-1:0]  pen_x_adv;
    logic                     emit_adv;
    logic                     emit_free;
    logic                     load;
    logic                     out_free;

    logic signed [WIDE_W-1:0] vx;
    logic signed [WIDE_W-1:0] vy;

    assign rect_w_wide = $signed(WIDE_W'(cfg.rect_width));
    assign rect_h_wide = $signed(WIDE_W'(cfg.rect_height));

    assign pop      = (state_reg == ST_DECODE) && !q_empty;
    assign pen_x_e  = head_item.start ? '0 : pen_x_reg;
    assign pen_y_e  = head_item.start ? '0 : pen_y_reg;
    assign halted_e = head_item.start ? 1'b0 : halted_reg;
    assign nl_y     = sat24(WIDE_W'(pen_y_e) + WIDE_W'(cfg.line_h));
    assign wrap     = (WIDE_W'(pen_x_e) + WIDE_W'(head_item.qw)) > rect_w_wide;

    assign pen_y_w   = wrap_reg ? ny_reg : pen_y_reg;
    assign pen_x_w   = wrap_reg ? '0 : pen_x_reg;
    assign halt      = (WIDE_W'(pen_y_w) + WIDE_W'(g_reg.qh)) >= rect_h_wide;
    assign ox        = WIDE_W'(pen_x_w) + WIDE_W'(g_reg.lx);
    assign oy        = WIDE_W'(pen_y_w) + WIDE_W'(cfg.asc_s) - WIDE_W'(g_reg.y1);
    assign pen_x_adv = sat24(WIDE_W'(pen_x_w) + WIDE_W'(g_reg.adv));

    assign out_free  = !out_valid_reg || vtx.ready;
    assign emit_adv  = busy_reg && out_free;
    assign emit_free = !busy_reg || (emit_adv && (k_reg == LAST_VERT));
    assign load      = (state_reg == ST_PLACE) && !halt && emit_free;

    always_comb
    begin
        state_next  = state_reg;
        pen_x_next  = pen_x_reg;
        pen_y_next  = pen_y_reg;
        halted_next = halted_reg;
        case (state_reg)
            ST_DECODE:
            begin
                if (pop)
                begin
                    halted_next = halted_e;
                    if (!halted_e)
                    begin
                        if (head_item.is_nl)
                        begin
                            pen_x_next = '0;
                            pen_y_next = nl_y;
                        end
                        else
                        begin
                            pen_x_next = pen_x_e;
                            pen_y_next = pen_y_e;
                            state_next = ST_PLACE;
                        end
                    end
                end
            end
            ST_PLACE:
            begin
                if (halt)
                begin
                    halted_next = 1'b1;
                    pen_x_next  = pen_x_w;
                    pen_y_next  = pen_y_w;
                    state_next  = ST_DECODE;
                end
                else if (emit_free)
                begin
                    pen_x_next = pen_x_adv;
                    pen_y_next = pen_y_w;
                    state_next = ST_DECODE;
                end
            end
            default:
            begin
                state_next = ST_DECODE;
            end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        if (load)
        begin
            busy_next = 1'b1;
            k_next    = '0;
        end
        else if (emit_adv)
        begin
            k_next = k_reg + VCNT_W'(1);
            if (k_reg == LAST_VERT)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_DECODE;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            halted_reg    <= 1'b0;
            busy_reg      <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pen_x_reg  <= pen_x_next;
            pen_y_reg  <= pen_y_next;
            halted_reg <= halted_next;
            busy_reg   <= busy_next;
            k_reg      <= k_next;
            if (emit_adv)
                out_valid_reg <= 1'b1;
            else if (vtx.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && !halted_e && !head_item.is_nl)
        begin
            wrap_reg <= wrap;
            ny_reg   <= nl_y;
            g_reg    <= head_item;
        end
        if (load)
        begin
            e_ox_reg <= ox;
            e_oy_reg <= oy;
            e_qw_reg <= g_reg.qw;
            e_qh_reg <= g_reg.qh;
            e_au_reg <= g_reg.au;
            e_av_reg <= g_reg.av;
            e_aw_reg <= g_reg.aw;
            e_ah_reg <= g_reg.ah;
        end
    end

    assign vx = e_ox_reg + (CORNER_X[k_reg] ? WIDE_W'(e_qw_reg) : '0);
    assign vy = e_oy_reg + (CORNER_Y[k_reg] ? WIDE_W'(e_qh_reg) : '0);

    always_ff @(posedge clk)
    begin
        if (emit_adv)
        begin
            out_x_reg      <= sat24(vx);
            out_y_reg      <= sat24(vy);
            out_u_reg      <= TEX_W'(e_au_reg) + (CORNER_X[k_reg] ? TEX_W'(e_aw_reg) : '0);
            out_v_reg      <= TEX_W'(e_av_reg) + (CORNER_Y[k_reg] ? TEX_W'(e_ah_reg) : '0);
            out_colour_reg <= cfg.colour_rgb;
            out_last_reg   <= (k_reg == LAST_VERT);
        end
    end

    assign vtx.valid         = out_valid_reg;
    assign vtx.vertex_x      = out_x_reg;
    assign vtx.vertex_y      = out_y_reg;
    assign vtx.tex_u         = out_u_reg;
    assign vtx.tex_v         = out_v_reg;
    assign vtx.vertex_colour = out_colour_reg;
    assign vtx.last_vertex   = out_last_reg;

    assign stat.halted = halted_reg;
    assign stat.busy   = busy_reg;
    assign stat.load   = load;

endmodule
`default_nettype wire

### hdl/glyph_quad_layout.sv
// Glyph quad layout top level: config, front end, queue, back end.
// A glyph word passes the front end registers, the queue, the decode and place steps and the vertex output register.
// Throughput is set by the output port: one vertex per cycle while the sink is ready.
// A newline is handled in the back end decode step alone; a glyph passes decode and place,
// overlapped with the previous quad's emission.
// Reset: config registers to defaults, pen at origin, halt clear, queue empty.
`default_nettype none
`include "glyph_quad_layout_macros.svh"
module glyph_quad_layout (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [glq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [glq_pkg::CFG_DATA_W-1:0] cfg_data,
    glq_req_if.sink                        req,
    glq_vtx_if.source                      vtx
);
    import glq_pkg::*;

    cfg_t       cfg;
    logic       push;
    item_t      push_item;
    item_t      head_item;
    logic       pop;
    q_stat_t    q_stat;
    back_stat_t back_stat;

    glq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    glq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req       (req),
        .q_full    (q_stat.full),
        .push      (push),
        .push_item (push_item)
    );

    glq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    glq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head_item (head_item),
        .q_empty   (q_stat.empty),
        .pop       (pop),
        .vtx       (vtx),
        .stat      (back_stat)
    );

    `GLQ_ASSERT_IMP(a_queue_bound, 1'b1, q_stat.count <= Q_CNT_W'(Q_DEPTH))
    `GLQ_ASSERT_IMP(a_no_load_halted, back_stat.load, !back_stat.halted)
    `GLQ_ASSERT_NEXT(a_load_busy, back_stat.load, back_stat.busy)

endmodule
`default_nettype wire

### verif/tb_glyph_quad_layout.sv
// Self-checking testbench: glyph/newline words in, predicted vertex stream compared per field.
`timescale 1ns / 100ps
module tb_glyph_quad_layout;
    import glq_pkg::*;

    localparam longint POS_MAX     = 64'sd8388607;
    localparam longint POS_MIN     = -64'sd8388608;
    localparam logic [5:0] X_SPAN  = 6'b011100;
    localparam logic [5:0] Y_SPAN  = 6'b110001;
    localparam int STALL_LEN       = 400;
    localparam int DRAIN_LIMIT     = 50000;
    localparam int TAIL_CYCLES     = 24;

    typedef struct packed {
        logic                      nl;
        logic                      sot;
        logic signed [UNITS_W-1:0] adv;
        logic signed [UNITS_W-1:0] lsb;
        logic signed [UNITS_W-1:0] x0;
        logic signed [UNITS_W-1:0] y0;
        logic signed [UNITS_W-1:0] x1;
        logic signed [UNITS_W-1:0] y1;
        logic [ATLAS_W-1:0]        au;
        logic [ATLAS_W-1:0]        av;
        logic [ATLAS_W-1:0]        aw;
        logic [ATLAS_W-1:0]        ah;
    } glyph_word_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [TEX_W-1:0]        u;
        logic [TEX_W-1:0]        v;
        logic [COLOUR_W-1:0]     rgb;
        logic                    last;
    } vertex_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic        drv_valid = 1'b0;
    glyph_word_t drv_word = '0;
    logic        req_taken = 1'b0;
    logic        sink_ready = 1'b0;

    glyph_word_t glyph_words[$];
    vertex_t     expected_verts[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          stall_reqs = 0;
    int          stall_seen = 0;
    int          stall_left = 0;

    // layout state and register copy
    longint                    pen_x = 0;
    longint                    pen_y = 0;
    bit                        halted = 1'b0;
    logic [SCALE_W-1:0]        cfg_scale = SCALE_RESET;
    logic [PAD_W-1:0]          cfg_pad = '0;
    logic signed [UNITS_W-1:0] cfg_asc = '0;
    logic signed [UNITS_W-1:0] cfg_desc = '0;
    logic signed [UNITS_W-1:0] cfg_gap = '0;
    logic [RECT_W-1:0]         cfg_width = RECT_RESET;
    logic [RECT_W-1:0]         cfg_height = RECT_RESET;
    logic [COLOUR_W-1:0]       cfg_rgb = COLOUR_RESET;

    glq_req_if req_ch ();
    glq_vtx_if vtx_ch ();

    assign req_ch.valid         = drv_valid;
    assign req_ch.req_type      = drv_word.nl;
    assign req_ch.start_of_text = drv_word.sot;
    assign req_ch.advance       = drv_word.adv;
    assign req_ch.left_bearing  = drv_word.lsb;
    assign req_ch.box_x0        = drv_word.x0;
    assign req_ch.box_y0        = drv_word.y0;
    assign req_ch.box_x1        = drv_word.x1;
    assign req_ch.box_y1        = drv_word.y1;
    assign req_ch.atlas_u       = drv_word.au;
    assign req_ch.atlas_v       = drv_word.av;
    assign req_ch.atlas_w       = drv_word.aw;
    assign req_ch.atlas_h       = drv_word.ah;
    assign vtx_ch.ready         = sink_ready;

    glyph_quad_layout u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .vtx       (vtx_ch)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("glyph_quad_layout: mismatch");
        $finish;
    end

    // font units to Q.8 pixels, round half up
    function automatic longint to_px(input logic signed [UNITS_W-1:0] v);
        return (longint'(v) * longint'(cfg_scale) + 64'sd2048) >>> 12;
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v > POS_MAX)
            return POS_MAX;
        if (v < POS_MIN)
            return POS_MIN;
        return v;
    endfunction

    function automatic longint line_step();
        return to_px(cfg_asc) - to_px(cfg_desc) + to_px(cfg_gap);
    endfunction

    task automatic report(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic add_word(input glyph_word_t w);
        glyph_words.insert(glyph_words.size(), w);
    endtask

    task automatic place_glyph(input glyph_word_t w);
        longint  adv;
        longint  x0;
        longint  y1;
        longint  qw;
        longint  qh;
        longint  ox;
        longint  oy;
        vertex_t vt;
        if (w.sot)
        begin
            pen_x = 0;
            pen_y = 0;
            halted = 1'b0;
        end
        if (halted)
            return;
        if (w.nl == REQ_NEWLINE)
        begin
            pen_y = clamp_pos(pen_y + line_step());
            pen_x = 0;
            return;
        end
        adv = to_px(w.adv);
        x0  = to_px(w.x0);
        y1  = to_px(w.y1);
        qw  = to_px(w.x1) - x0 + 2 * longint'(cfg_pad);
        qh  = y1 - to_px(w.y0) + 2 * longint'(cfg_pad);
        if (pen_x + qw > longint'(cfg_width))
        begin
            pen_y = clamp_pos(pen_y + line_step());
            pen_x = 0;
        end
        if (pen_y + qh >= longint'(cfg_height))
        begin
            halted = 1'b1;
            return;
        end
        ox = pen_x + to_px(w.lsb) + x0;
        oy = pen_y + to_px(cfg_asc) - y1;
        for (int k = 0; k < 6; k++)
        begin
            vt.x    = POS_W'(clamp_pos(ox + (X_SPAN[k] ? qw : 64'sd0)));
            vt.y    = POS_W'(clamp_pos(oy + (Y_SPAN[k] ? qh : 64'sd0)));
            vt.u    = {1'b0, w.au} + (X_SPAN[k] ? {1'b0, w.aw} : 17'd0);
            vt.v    = {1'b0, w.av} + (Y_SPAN[k] ? {1'b0, w.ah} : 17'd0);
            vt.rgb  = cfg_rgb;
            vt.last = (k == 5);
            expected_verts.insert(expected_verts.size(), vt);
        end
        pen_x = clamp_pos(pen_x + adv);
    endtask

    task automatic check_field(input string name, input logic signed [63:0] got,
                               input logic signed [63:0] want);
        if (got !== want)
            report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task automatic check_vertex();
        vertex_t want;
        if (expected_verts.size() == 0)
            report("vertex with nothing expected");
        else
        begin
            want = expected_verts.pop_front();
            check_field("vertex_x", vtx_ch.vertex_x, want.x);
            check_field("vertex_y", vtx_ch.vertex_y, want.y);
            check_field("tex_u", {1'b0, vtx_ch.tex_u}, {1'b0, want.u});
            check_field("tex_v", {1'b0, vtx_ch.tex_v}, {1'b0, want.v});
            check_field("vertex_colour", {1'b0, vtx_ch.vertex_colour}, {1'b0, want.rgb});
            check_field("last_vertex", {1'b0, vtx_ch.last_vertex}, {1'b0, want.last});
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            drv_valid <= 1'b0;
        else if (!drv_valid || req_taken)
        begin
            if (glyph_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                drv_word  <= glyph_words.pop_front();
                drv_valid <= 1'b1;
            end
            else
                drv_valid <= 1'b0;
        end
    end

    // vertex receiver, with long hold-off on request
    always @(negedge clk)
    begin
        if (stall_seen != stall_reqs)
        begin
            stall_seen = stall_reqs;
            stall_left = STALL_LEN;
            sink_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            sink_ready <= 1'b0;
        end
        else
            sink_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        req_taken <= drv_valid && req_ch.ready;
        if (rst_n)
        begin
            if (drv_valid && req_ch.ready)
                place_glyph(drv_word);
            if (vtx_ch.valid && vtx_ch.ready)
                check_vertex();
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_GLYPH_SCALE: cfg_scale  = data[SCALE_W-1:0];
            REG_PAD_PIXELS:  cfg_pad    = data[PAD_W-1:0];
            REG_ASCENDER:    cfg_asc    = data[UNITS_W-1:0];
            REG_DESCENDER:   cfg_desc   = data[UNITS_W-1:0];
            REG_LINE_GAP:    cfg_gap    = data[UNITS_W-1:0];
            REG_RECT_WIDTH:  cfg_width  = data[RECT_W-1:0];
            REG_RECT_HEIGHT: cfg_height = data[RECT_W-1:0];
            REG_COLOUR:      cfg_rgb    = data[COLOUR_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_regs(input int scale, input int pad, input int asc, input int desc,
                            input int gap, input int width, input int height, input int rgb);
        write_reg(REG_GLYPH_SCALE, CFG_DATA_W'(scale));
        write_reg(REG_PAD_PIXELS, CFG_DATA_W'(pad));
        write_reg(REG_ASCENDER, CFG_DATA_W'(UNITS_W'(asc)));
        write_reg(REG_DESCENDER, CFG_DATA_W'(UNITS_W'(desc)));
        write_reg(REG_LINE_GAP, CFG_DATA_W'(UNITS_W'(gap)));
        write_reg(REG_RECT_WIDTH, CFG_DATA_W'(width));
        write_reg(REG_RECT_HEIGHT, CFG_DATA_W'(height));
        write_reg(REG_COLOUR, CFG_DATA_W'(rgb));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_layout();
        set_regs(int'($urandom_range(32768, 8192)), int'($urandom_range(1024, 0)),
                 int'($urandom_range(1000, 600)), -int'($urandom_range(300, 100)),
                 int'($urandom_range(200, 0)), int'($urandom_range(80000, 8000)),
                 int'($urandom_range(120000, 20000)), int'($urandom_range(24'hFFFFFF, 0)));
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        while ((glyph_words.size() != 0 || drv_valid || expected_verts.size() != 0)
               && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_verts.size() != 0)
        begin
            report($sformatf("%0d vertices never arrived", expected_verts.size()));
            expected_verts.delete();
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic glyph_word_t glyph_word(input bit sot, input int adv, input int lsb,
                                               input int x0, input int y0, input int x1,
                                               input int y1, input int au, input int av,
                                               input int aw, input int ah);
        glyph_word_t w;
        w.nl  = REQ_GLYPH;
        w.sot = sot;
        w.adv = UNITS_W'(adv);
        w.lsb = UNITS_W'(lsb);
        w.x0  = UNITS_W'(x0);
        w.y0  = UNITS_W'(y0);
        w.x1  = UNITS_W'(x1);
        w.y1  = UNITS_W'(y1);
        w.au  = ATLAS_W'(au);
        w.av  = ATLAS_W'(av);
        w.aw  = ATLAS_W'(aw);
        w.ah  = ATLAS_W'(ah);
        return w;
    endfunction

    function automatic glyph_word_t noise_word();
        glyph_word_t w;
        w.nl  = 1'($urandom);
        w.sot = ($urandom_range(4) == 0);
        w.adv = UNITS_W'($urandom);
        w.lsb = UNITS_W'($urandom);
        w.x0  = UNITS_W'($urandom);
        w.y0  = UNITS_W'($urandom);
        w.x1  = UNITS_W'($urandom);
        w.y1  = UNITS_W'($urandom);
        w.au  = ATLAS_W'($urandom);
        w.av  = ATLAS_W'($urandom);
        w.aw  = ATLAS_W'($urandom);
        w.ah  = ATLAS_W'($urandom);
        return w;
    endfunction

    function automatic glyph_word_t newline_word(input bit sot);
        glyph_word_t w;
        w     = noise_word();
        w.nl  = REQ_NEWLINE;
        w.sot = sot;
        return w;
    endfunction

    // plausible glyph metrics, occasionally mirrored box
    function automatic glyph_word_t text_glyph(input bit sot);
        int x0;
        int x1;
        int y0;
        x0 = int'($urandom_range(150)) - 50;
        x1 = x0 + int'($urandom_range(600));
        y0 = int'($urandom_range(300)) - 250;
        if ($urandom_range(19) == 0)
            return glyph_word(sot, int'($urandom_range(700)), int'($urandom_range(180)) - 60,
                              x1, y0, x0, y0 - int'($urandom_range(300)),
                              int'($urandom), int'($urandom), int'($urandom), int'($urandom));
        return glyph_word(sot, int'($urandom_range(700)), int'($urandom_range(180)) - 60,
                          x0, y0, x1, y0 + int'($urandom_range(900)),
                          int'($urandom), int'($urandom), int'($urandom), int'($urandom));
    endfunction

    task automatic queue_text(input int n);
        int r;
        if ($urandom_range(9) == 0)
            add_word(newline_word(1'b1));
        else
            add_word(text_glyph(1'b1));
        for (int i = 1; i < n; i++)
        begin
            r = int'($urandom_range(99));
            if (r < 12)
                add_word(newline_word(1'b0));
            else if (r < 17)
                add_word(noise_word());
            else
                add_word(text_glyph(1'b0));
        end
    endtask

    initial
    begin
        int queued;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // reset registers: one unit is one pixel, no line height
        add_word(glyph_word(1, 10, 1, 0, 0, 8, 12, 0, 0, 0, 0));
        add_word(glyph_word(0, 9, 0, 1, -3, 7, 9, 65535, 65535, 65535, 65535));
        add_word(glyph_word(0, 32767, 32767, 32767, 32767, 32767, 32767,
                            0, 65535, 0, 65535));
        add_word(glyph_word(0, -32768, -32768, -32768, -32768, -32768, -32768,
                            65535, 0, 65535, 0));
        add_word(glyph_word(0, 5, 0, -32768, 0, 32767, 0, 1, 2, 3, 4));
        add_word(newline_word(1'b0));
        add_word(glyph_word(0, 5, 0, 0, -32768, 10, 32767, 5, 6, 7, 8));
        add_word(glyph_word(0, 5, 0, 0, 0, 4, 4, 9, 9, 9, 9));
        add_word(newline_word(1'b0));
        add_word(newline_word(1'b1));
        add_word(glyph_word(0, 20, -5, 100, 50, -100, -50, 100, 200, 300, 400));
        add_word(glyph_word(0, 32767, 0, 0, 0, 0, 0, 11, 12, 13, 14));
        add_word(glyph_word(0, 32767, 0, 0, 0, 0, 0, 15, 16, 17, 18));
        drain();

        set_regs(24'hFFFFFF, 16'hFFFF, 32767, -32768, 32767, 23'h7FFFFF, 23'h7FFFFF, 0);
        add_word(glyph_word(1, 100, 10, 0, 0, 0, 0, 1, 1, 1, 1));
        add_word(glyph_word(0, 32767, -32768, 0, 0, 0, 0, 2, 2, 2, 2));
        add_word(glyph_word(0, 1, 0, 0, 0, 0, 0, 3, 3, 3, 3));
        add_word(newline_word(1'b1));
        add_word(glyph_word(1, -32768, -32768, -32768, -32768, -32768, -32768,
                            65535, 65535, 0, 0));
        drain();

        set_regs(0, 0, -32768, 32767, -32768, 0, 0, 24'hFFFFFF);
        add_word(glyph_word(1, 50, 3, 1, 2, 3, 4, 5, 6, 7, 8));
        add_word(newline_word(1'b1));
        add_word(glyph_word(0, 50, 3, 1, 2, 3, 4, 5, 6, 7, 8));
        drain();

        set_regs(0, 0, -32768, 32767, -32768, 0, 1, 24'h5A5A5A);
        add_word(glyph_word(1, 7, 3, 2, 1, 9, 8, 40, 50, 60, 70));
        add_word(glyph_word(0, 7, 3, 2, 1, 9, 8, 41, 51, 61, 71));
        drain();

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 15 : (mode == 1) ? 55 : 0;
            recv_idle_pct = (mode == 0) ? 55 : (mode == 1) ? 15 : 0;
            for (int pass_idx = 0; pass_idx < 3; pass_idx++)
            begin
                random_layout();
                if (mode == 0 && pass_idx == 0)
                    stall_reqs++;
                queued = 0;
                while (queued < 38)
                begin
                    queued += int'($urandom_range(16, 4));
                    queue_text(queued < 38 ? int'($urandom_range(16, 4)) : 4);
                end
                drain();
            end
        end

        if (mismatches == 0)
            $display("glyph_quad_layout: match");
        else
            $display("glyph_quad_layout: mismatch");
        $finish;
    end

endmodule
